// ----- src/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// shared types, format codes and helper functions for the texel decoder
// ----------------------------------------------------------------------------
package tfd_pkg;

  // format codes of the texture_format register
  localparam logic [3:0] FMT_I4     = 4'd0;
  localparam logic [3:0] FMT_I8     = 4'd1;
  localparam logic [3:0] FMT_IA4    = 4'd2;
  localparam logic [3:0] FMT_RGB565 = 4'd4;
  localparam logic [3:0] FMT_RGB5A3 = 4'd5;
  localparam logic [3:0] FMT_CMPR   = 4'd14;

  localparam logic [3:0] FMT_RESET  = FMT_I4;

  // input item
  typedef struct packed {
    logic [15:0] texel_word;
    logic        nibble_select;
    logic [15:0] color_zero;
    logic [15:0] color_one;
    logic [31:0] index_word;
    logic [3:0]  texel_position;
  } texel_in_t;

  // result item
  typedef struct packed {
    logic [15:0] pixel_argb1555;
    logic        bad_format;
  } texel_out_t;

  // opaque 1555 pixel from three 5-bit channels
  function automatic logic [15:0] pack555(input logic [4:0] r, input logic [4:0] g,
                                          input logic [4:0] b);
    return {1'b1, r, g, b};
  endfunction

  // x / 3 for x < 256 by reciprocal multiply (171 / 512)
  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd171;
    return prod[16:9];
  endfunction

endpackage

// ----- src/texel_format_decoder_top.sv -----
// ----------------------------------------------------------------------------
// texel_format_decoder_top
// texel decoder: one texture texel in, one 1555 pixel out per item
// the result strobe is registered through the input reg and then the result reg
// throughput: one item per cycle, busy is never raised
// the receiver cannot stall, each result shows for exactly one cycle
// reset (rst, sync, active high) clears the valid pipeline and sets format to I4
// config writes are always ready and take effect on the next cycle
// ----------------------------------------------------------------------------
module texel_format_decoder_top (
  input  logic                 clk,
  input  logic                 rst,

  // item input, command style
  input  logic                 start,
  output logic                 busy,
  input  tfd_pkg::texel_in_t   texel_in,

  // format register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data,

  // result output, one-cycle strobe
  output logic                 result_valid,
  output tfd_pkg::texel_out_t  result
);

  // format register
  logic [3:0] texture_format;

  // input register stage
  logic                stage_valid;
  tfd_pkg::texel_in_t  stage_texel;

  // decode output ahead of the result register
  tfd_pkg::texel_out_t result_next;

  // no loop or shared unit inside: a fresh item can enter every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // format register; the user must write it only while no item is in flight, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= tfd_pkg::FMT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      texture_format <= cfg_data;
    end
  end

  // input register: capture the item on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_texel <= texel_in;
    end
  end

  // short decode logic between the two registers
  tfd_decode u_decode (
    .texture_format (texture_format),
    .texel          (stage_texel),
    .pixel          (result_next)
  );

  // result register: strobe high for one cycle per item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      result <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  // every result strobe traces back to an accepted item, through the input and result registers
  a_strobe_from_start: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, 2))
    else $error("result strobe without an accepted item");

  // an unsupported format gives a zero pixel
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.bad_format) |-> (result.pixel_argb1555 == 16'h0000))
    else $error("bad format with nonzero pixel");

  // a decoded pixel is always opaque
  a_alpha_set: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.bad_format) |-> result.pixel_argb1555[15])
    else $error("decoded pixel without alpha bit");
`endif

endmodule

// ----- src/tfd_cmpr.sv -----
// ----------------------------------------------------------------------------
// tfd_cmpr
// cmpr palette build from two 565 endpoints and 2-bit index pick
// ----------------------------------------------------------------------------
module tfd_cmpr (
  input  logic [15:0] color_zero,
  input  logic [15:0] color_one,
  input  logic [31:0] index_word,
  input  logic [3:0]  texel_position,
  output logic [15:0] color
);

  logic [4:0]  r0, r1, b0, b1;
  logic [5:0]  g0, g1;
  logic [7:0]  r_two, r_thr, g_two, g_thr, b_two, b_thr;
  logic [6:0]  r_mid, b_mid;
  logic [7:0]  g_mid;
  logic [15:0] entry2, entry3;
  logic [31:0] shifted;
  logic [1:0]  sel;

  assign r0 = color_zero[15:11];
  assign g0 = color_zero[10:5];
  assign b0 = color_zero[4:0];
  assign r1 = color_one[15:11];
  assign g1 = color_one[10:5];
  assign b1 = color_one[4:0];

  // two-thirds / one-third blends per component
  assign r_two = tfd_pkg::div3({2'b00, r0, 1'b0} + {3'b000, r1});
  assign r_thr = tfd_pkg::div3({3'b000, r0} + {2'b00, r1, 1'b0});
  assign g_two = tfd_pkg::div3({1'b0, g0, 1'b0} + {2'b00, g1});
  assign g_thr = tfd_pkg::div3({2'b00, g0} + {1'b0, g1, 1'b0});
  assign b_two = tfd_pkg::div3({2'b00, b0, 1'b0} + {3'b000, b1});
  assign b_thr = tfd_pkg::div3({3'b000, b0} + {2'b00, b1, 1'b0});

  // midpoint sums
  assign r_mid = {2'b00, r0} + {2'b00, r1};
  assign g_mid = {2'b00, g0} + {2'b00, g1};
  assign b_mid = {2'b00, b0} + {2'b00, b1};

  always_comb begin
    if (color_zero > color_one) begin
      entry2 = {r_two[4:0], g_two[5:0], b_two[4:0]};
      entry3 = {r_thr[4:0], g_thr[5:0], b_thr[4:0]};
    end else begin
      entry2 = {r_mid[5:1], g_mid[6:1], b_mid[5:1]};
      entry3 = 16'h0000;
    end
  end

  // texel 0 sits in the top two bits: shift by 2 * (15 - position)
  assign shifted = index_word >> {~texel_position, 1'b0};
  assign sel     = shifted[1:0];

  always_comb begin
    case (sel)
      2'd0:    color = color_zero;
      2'd1:    color = color_one;
      2'd2:    color = entry2;
      2'd3:    color = entry3;
      default: color = 16'h0000;
    endcase
  end

endmodule

// ----- src/tfd_decode.sv -----
// ----------------------------------------------------------------------------
// tfd_decode
// per-format texel decode into one 1555 pixel
// ----------------------------------------------------------------------------
module tfd_decode (
  input  logic [3:0]         texture_format,
  input  tfd_pkg::texel_in_t texel,
  output tfd_pkg::texel_out_t pixel
);

  logic [7:0]  byte_val;
  logic [3:0]  nib;
  logic [15:0] word;
  logic [15:0] cmpr_color;

  assign word     = texel.texel_word;
  assign byte_val = word[7:0];
  assign nib      = texel.nibble_select ? byte_val[3:0] : byte_val[7:4];

  tfd_cmpr u_cmpr (
    .color_zero     (texel.color_zero),
    .color_one      (texel.color_one),
    .index_word     (texel.index_word),
    .texel_position (texel.texel_position),
    .color          (cmpr_color)
  );

  always_comb begin
    pixel.pixel_argb1555 = 16'h0000;
    pixel.bad_format     = 1'b0;
    case (texture_format)
      tfd_pkg::FMT_I4: begin
        pixel.pixel_argb1555 = tfd_pkg::pack555({nib, nib[3]}, {nib, nib[3]}, {nib, nib[3]});
      end
      tfd_pkg::FMT_I8: begin
        pixel.pixel_argb1555 = tfd_pkg::pack555(byte_val[7:3], byte_val[7:3], byte_val[7:3]);
      end
      tfd_pkg::FMT_IA4: begin
        pixel.pixel_argb1555 = tfd_pkg::pack555({byte_val[3:0], byte_val[3]},
                                                {byte_val[3:0], byte_val[3]},
                                                {byte_val[3:0], byte_val[3]});
      end
      tfd_pkg::FMT_RGB565: begin
        pixel.pixel_argb1555 = tfd_pkg::pack555(word[15:11], word[10:6], word[4:0]);
      end
      tfd_pkg::FMT_RGB5A3: begin
        if (word[15]) begin
          pixel.pixel_argb1555 = tfd_pkg::pack555(word[14:10], word[9:5], word[4:0]);
        end else begin
          pixel.pixel_argb1555 = tfd_pkg::pack555({word[11:8], 1'b0}, {word[7:4], 1'b0},
                                                  {word[3:0], 1'b0});
        end
      end
      tfd_pkg::FMT_CMPR: begin
        pixel.pixel_argb1555 = tfd_pkg::pack555(cmpr_color[15:11], cmpr_color[10:6],
                                                cmpr_color[4:0]);
      end
      default: begin
        pixel.pixel_argb1555 = 16'h0000;
        pixel.bad_format     = 1'b1;
      end
    endcase
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for texel_format_decoder_top: a queue-fed driver sends
// texels under changing formats and sender gaps, a monitor decodes each
// accepted texel on its own and compares every pixel strobe with the oldest
// decoded value
// ----------------------------------------------------------------------------
module tb;

  // unsupported code that sits between IA4 and RGB565
  localparam logic [3:0] FMT_HOLE      = 4'd3;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         RANDOM_ITEMS  = 1750;
  localparam int         REPORT_LIMIT  = 10;

  // what the driver does with the head of its queue
  typedef enum logic [1:0] {
    OP_ITEM,    // send one texel
    OP_FORMAT,  // write the format register once nothing is in flight
    OP_IDLE,    // change the sender gap rate (percent)
    OP_SETTLE   // hold off until every pixel in flight has come back
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    tfd_pkg::texel_in_t texel;
    logic [6:0]         value;
  } drive_op_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  tfd_pkg::texel_in_t  texel_in = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_data = '0;
  logic                result_valid;
  tfd_pkg::texel_out_t result;

  drive_op_t           drive_ops[$];      // filled up front, drained by the driver
  tfd_pkg::texel_out_t pending_pixels[$]; // decoded pixels still owed by the block
  logic [3:0]          format_shadow = tfd_pkg::FMT_RESET;
  int unsigned         texels_sent = 0;
  int unsigned         pixels_seen = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         sender_idle_pct = 0;

  texel_format_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .texel_in     (texel_in),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoding, written per channel at 8 bits and then cut down to 5
  // ---------------------------------------------------------------------------

  // opaque 1555 pixel from 8-bit channels, keeps the top five bits of each
  function automatic logic [15:0] to_1555(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {1'b1, r[7:3], g[7:3], b[7:3]};
  endfunction

  // weighted mean of two 565 colors, each component truncated on its own
  function automatic logic [15:0] mix565(input int unsigned wa, input int unsigned wb,
                                         input logic [15:0] ca, input logic [15:0] cb);
    int unsigned sum, r, g, b;
    sum = wa + wb;
    r = (wa * ca[15:11] + wb * cb[15:11]) / sum;
    g = (wa * ca[10:5] + wb * cb[10:5]) / sum;
    b = (wa * ca[4:0] + wb * cb[4:0]) / sum;
    return {5'(r), 6'(g), 5'(b)};
  endfunction

  function automatic tfd_pkg::texel_out_t decode_texel(input tfd_pkg::texel_in_t t,
                                                       input logic [3:0] fmt);
    tfd_pkg::texel_out_t o;
    logic [15:0]         w;
    logic [7:0]          lo;
    logic [3:0]          nib;
    logic [15:0]         palette [4];
    logic [15:0]         chosen;
    logic [1:0]          pick;
    w = t.texel_word;
    lo = w[7:0];
    o.bad_format = 1'b0;
    o.pixel_argb1555 = '0;
    case (fmt)
      tfd_pkg::FMT_I4: begin
        nib = t.nibble_select ? lo[3:0] : lo[7:4];
        o.pixel_argb1555 = to_1555({nib, nib}, {nib, nib}, {nib, nib});
      end
      tfd_pkg::FMT_I8: begin
        o.pixel_argb1555 = to_1555(lo, lo, lo);
      end
      tfd_pkg::FMT_IA4: begin
        o.pixel_argb1555 = to_1555({lo[3:0], lo[3:0]}, {lo[3:0], lo[3:0]}, {lo[3:0], lo[3:0]});
      end
      tfd_pkg::FMT_RGB565: begin
        o.pixel_argb1555 = to_1555({w[15:11], 3'b0}, {w[10:5], 2'b0}, {w[4:0], 3'b0});
      end
      tfd_pkg::FMT_RGB5A3: begin
        // opaque 555 when the top bit is set, else 4443 with alpha dropped
        if (w[15]) begin
          o.pixel_argb1555 = to_1555({w[14:10], 3'b0}, {w[9:5], 3'b0}, {w[4:0], 3'b0});
        end else begin
          o.pixel_argb1555 = to_1555({w[11:8], 4'b0}, {w[7:4], 4'b0}, {w[3:0], 4'b0});
        end
      end
      tfd_pkg::FMT_CMPR: begin
        palette[0] = t.color_zero;
        palette[1] = t.color_one;
        if (t.color_zero > t.color_one) begin
          palette[2] = mix565(2, 1, t.color_zero, t.color_one);
          palette[3] = mix565(1, 2, t.color_zero, t.color_one);
        end else begin
          // midpoint and black
          palette[2] = mix565(1, 1, t.color_zero, t.color_one);
          palette[3] = '0;
        end
        // texel 0 owns the top two index bits
        pick = 2'(t.index_word >> (30 - 2 * int'(t.texel_position)));
        chosen = palette[pick];
        o.pixel_argb1555 = to_1555({chosen[15:11], 3'b0}, {chosen[10:5], 2'b0},
                                   {chosen[4:0], 3'b0});
      end
      default: begin
        o.bad_format = 1'b1;
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic tfd_pkg::texel_in_t random_texel();
    tfd_pkg::texel_in_t t;
    t.texel_word     = 16'($urandom);
    t.nibble_select  = 1'($urandom);
    t.color_zero     = 16'($urandom);
    t.color_one      = 16'($urandom);
    t.index_word     = $urandom;
    t.texel_position = 4'($urandom);
    // pull in the corners of the word now and then
    case ($urandom_range(9))
      0: t.texel_word = '0;
      1: t.texel_word = '1;
      default: ;
    endcase
    // equal endpoints take the midpoint-and-black palette
    case ($urandom_range(11))
      0: t.color_one = t.color_zero;
      1: t.color_zero = '1;
      2: t.color_one = '0;
      3: t.color_zero = '0;
      default: ;
    endcase
    return t;
  endfunction

  task automatic queue_ctl(input op_kind_t kind, input logic [6:0] value);
    drive_op_t op;
    op.kind = kind;
    op.texel = '0;
    op.value = value;
    drive_ops.push_back(op);
  endtask

  task automatic queue_texel(input tfd_pkg::texel_in_t t);
    drive_op_t op;
    op.kind = OP_ITEM;
    op.texel = t;
    op.value = '0;
    drive_ops.push_back(op);
  endtask

  // directed texel: word based fields set, cmpr fields given separately
  task automatic queue_word(input logic [15:0] word, input logic nsel);
    tfd_pkg::texel_in_t t;
    t = random_texel();
    t.texel_word = word;
    t.nibble_select = nsel;
    queue_texel(t);
  endtask

  task automatic queue_block(input logic [15:0] c0, input logic [15:0] c1,
                             input logic [31:0] idx, input logic [3:0] pos);
    tfd_pkg::texel_in_t t;
    t = random_texel();
    t.color_zero = c0;
    t.color_one = c1;
    t.index_word = idx;
    t.texel_position = pos;
    queue_texel(t);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one texel or one format write at a time, gaps at the current rate
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic        send_texel, send_format;
    int unsigned sent_now;
    send_texel = 1'b0;
    send_format = 1'b0;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      sent_now = texels_sent + ((start && !busy) ? 1 : 0);
      texels_sent <= sent_now;
      if ((start && busy) || (cfg_valid && !cfg_ready)) begin
        // offer still open, keep it up
        send_texel = start;
        send_format = cfg_valid;
      end else if (drive_ops.size() != 0) begin
        // pixels_seen only lags the strobes, so equality means truly empty
        case (drive_ops[0].kind)
          OP_ITEM: begin
            if ($urandom_range(99) >= sender_idle_pct) begin
              texel_in <= drive_ops[0].texel;
              send_texel = 1'b1;
              void'(drive_ops.pop_front());
            end
          end
          OP_FORMAT: begin
            if (sent_now == pixels_seen) begin
              cfg_data <= drive_ops[0].value[3:0];
              send_format = 1'b1;
              void'(drive_ops.pop_front());
            end
          end
          OP_SETTLE: begin
            if (sent_now == pixels_seen) begin
              void'(drive_ops.pop_front());
            end
          end
          OP_IDLE: begin
            sender_idle_pct = 32'(drive_ops[0].value);
            void'(drive_ops.pop_front());
          end
          default: ;
        endcase
      end
      start <= send_texel;
      cfg_valid <= send_format;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: decode accepted texels, track format writes, check pixel strobes
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d, %s: expected %h, got %h", cycle_count, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    tfd_pkg::texel_out_t want;
    if (!rst) begin
      if (start && !busy) begin
        pending_pixels.push_back(decode_texel(texel_in, format_shadow));
      end
      if (cfg_valid && cfg_ready) begin
        format_shadow = cfg_data;
      end
      if (result_valid) begin
        pixels_seen <= pixels_seen + 1;
        if (pending_pixels.size() == 0) begin
          note_mismatch("pixel with no texel pending", '0, result.pixel_argb1555);
        end else begin
          want = pending_pixels.pop_front();
          if (result.pixel_argb1555 !== want.pixel_argb1555) begin
            note_mismatch("pixel_argb1555", want.pixel_argb1555, result.pixel_argb1555);
          end
          if (result.bad_format !== want.bad_format) begin
            note_mismatch("bad_format", 16'(want.bad_format), 16'(result.bad_format));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0]  supported [6];
    int unsigned idle_levels [3];
    int unsigned queued, seg_len, phase, pick;
    logic [3:0]  fmt;
    supported = '{tfd_pkg::FMT_I4, tfd_pkg::FMT_I8, tfd_pkg::FMT_IA4,
                  tfd_pkg::FMT_RGB565, tfd_pkg::FMT_RGB5A3, tfd_pkg::FMT_CMPR};
    idle_levels = '{0, 49, 31};

    // directed part, no gaps
    // i4 straight out of reset: high nibble, low nibble, all zero
    queue_word(16'hffab, 1'b0);
    queue_word(16'hffab, 1'b1);
    queue_word(16'h0000, 1'b0);
    // i8 ignores the upper byte
    queue_ctl(OP_FORMAT, 7'(tfd_pkg::FMT_I8));
    queue_word(16'h00ff, 1'b1);
    queue_word(16'hff00, 1'b0);
    // ia4 keeps the low nibble only
    queue_ctl(OP_FORMAT, 7'(tfd_pkg::FMT_IA4));
    queue_word(16'h00f5, 1'b0);
    queue_word(16'hff0a, 1'b1);
    queue_ctl(OP_FORMAT, 7'(tfd_pkg::FMT_RGB565));
    queue_word(16'hffff, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'hf81f, 1'b0);
    // rgb5a3: both the opaque 555 and the 4443 form
    queue_ctl(OP_FORMAT, 7'(tfd_pkg::FMT_RGB5A3));
    queue_word(16'h8000, 1'b0);
    queue_word(16'hffff, 1'b0);
    queue_word(16'h7fff, 1'b1);
    queue_word(16'h0000, 1'b0);
    // cmpr: every palette entry for c0 > c1, entries 2 and 3 for c0 < c1, and equal endpoints
    queue_ctl(OP_FORMAT, 7'(tfd_pkg::FMT_CMPR));
    queue_block(16'hffff, 16'h0000, 32'h1b00_0000, 4'd0);
    queue_block(16'hffff, 16'h0000, 32'h1b00_0000, 4'd1);
    queue_block(16'hffff, 16'h0000, 32'h1b00_0000, 4'd2);
    queue_block(16'hf7de, 16'h0821, 32'h1b00_0000, 4'd3);
    queue_block(16'h0000, 16'hffff, 32'h0000_00e4, 4'd12);
    queue_block(16'h0000, 16'hffff, 32'h0000_00e4, 4'd13);
    queue_block(16'h0821, 16'hf7de, 32'hffff_ffff, 4'd15);
    queue_block(16'h1234, 16'h1234, 32'h8000_0000, 4'd0);
    // unsupported codes, the top one among them
    queue_ctl(OP_FORMAT, 7'(FMT_HOLE));
    queue_word(16'h5a5a, 1'b1);
    queue_ctl(OP_FORMAT, 7'h0f);
    queue_word(16'ha5a5, 1'b0);
    queue_ctl(OP_FORMAT, 7'(tfd_pkg::FMT_I4));

    // random part in segments, each with its own format and gap rate
    queued = 0;
    phase = 0;
    while (queued < RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        fmt = supported[pick];
      end else if (pick < 8) begin
        fmt = tfd_pkg::FMT_CMPR;
      end else begin
        fmt = 4'($urandom_range(15));
      end
      queue_ctl(OP_FORMAT, 7'(fmt));
      queue_ctl(OP_IDLE, 7'(idle_levels[phase % 3]));
      seg_len = $urandom_range(20, 80);
      for (int unsigned i = 0; i < seg_len; i++) begin
        queue_texel(random_texel());
        // occasional full drain in the middle of a segment
        if ($urandom_range(99) == 0) begin
          queue_ctl(OP_SETTLE, '0);
        end
      end
      queued += seg_len;
      phase++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // everything handed over, then every pixel back, then a short tail
    while (drive_ops.size() != 0 || start || cfg_valid) begin
      @(posedge clk);
    end
    while (texels_sent != pixels_seen) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
